@@ rtl/bcq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcq_pkg: shared types and constants of the box count shape set query block
// Coordinate limits, table geometry, operation and status codes, FSM states
// and the command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package bcq_pkg;

    localparam int MAX_COORD   = 13;
    localparam int TUPLE_TOTAL = 13;

    localparam int DIG_W     = 4;                    // one coordinate digit
    localparam int SUM_W6    = 6;                    // sum of four digits
    localparam int ROW_W     = 1 << DIG_W;           // member bits per row
    localparam int ROW_DEPTH = 1 << (3 * DIG_W);     // rows addressed by a,b,c
    localparam int ROW_AW    = 3 * DIG_W;
    localparam int TAB_AW    = 4 * DIG_W;
    localparam int TAB_DEPTH = 1 << TAB_AW;
    localparam int CNT_W     = 10;                   // one prefix count
    localparam int TAB_W     = 2 * CNT_W;            // member and non-member
    localparam int ACC_W     = 16;                   // signed corner sum
    localparam int CORNERS   = 16;
    localparam int CQ_W      = 5;

    localparam logic [DIG_W-1:0]  LIM        = DIG_W'(MAX_COORD + 1);
    localparam logic [DIG_W-1:0]  MAX_DIG    = DIG_W'(MAX_COORD);
    localparam logic [SUM_W6-1:0] TOTAL      = SUM_W6'(TUPLE_TOTAL);
    localparam logic [SUM_W6-1:0] SEED_TOTAL = SUM_W6'(TUPLE_TOTAL + 4);

    typedef enum logic [1:0] {
        OP_MARK_IN  = 2'd0,
        OP_MARK_OUT = 2'd1,
        OP_BUILD    = 2'd2,
        OP_QUERY    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_BUILT   = 3'd1,
        STAT_UNBUILT = 3'd2,
        STAT_BAD     = 3'd3,
        STAT_EMPTY   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MARK_RD,
        S_MARK_WR,
        S_SEED_RD,
        S_SEED_WR,
        S_PASS_RD,
        S_PASS_WR,
        S_QUERY,
        S_QFIN
    } state_t;

    typedef struct packed {
        logic    load;        // capture the input word, rewind counters
        logic    clear;       // clear one member row
        logic    mark_wr;     // write back the marked member row
        logic    seed;        // member rows addressed from the sweep digits
        logic    seed_wr;     // seed and first running-sum write
        logic    pass_wr;     // running-sum write along the current axis
        logic    axis_dec;    // move on to the next axis
        logic    query;       // corner read and accumulate
        logic    emit;        // emit a result with the given code
        logic    emit_query;  // emit the query verdict
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic mark_bad;
        logic query_bad;
        logic query_empty;
        logic clr_last;
        logic inner_last;
        logic cnt_last;
        logic axis_zero;
        logic q_last;
    } sts_t;

endpackage : bcq_pkg
`default_nettype wire

@@ rtl/bcq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcq_ram: generic single-port RAM
// One read or write a cycle; read data registered.
// ----------------------------------------------------------------------------
module bcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule : bcq_ram
`default_nettype wire

@@ rtl/bcq_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcq_dp: datapath
// Member-bit RAM, combined prefix-count RAM, sweep and corner counters,
// running sums, corner accumulators and the result register.
// ----------------------------------------------------------------------------
module bcq_dp
    import bcq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [1:0]       operation,
    input  wire logic [DIG_W-1:0] first_low,
    input  wire logic [DIG_W-1:0] first_high,
    input  wire logic [DIG_W-1:0] second_low,
    input  wire logic [DIG_W-1:0] second_high,
    input  wire logic [DIG_W-1:0] third_low,
    input  wire logic [DIG_W-1:0] third_high,
    input  wire logic [DIG_W-1:0] fourth_low,
    input  wire logic [DIG_W-1:0] fourth_high,
    input  wire cmd_t             cmd,
    output      sts_t             sts,
    output      logic             done,
    output      logic             all_members,
    output      logic             any_member,
    output      logic [2:0]       status
);

    logic [DIG_W-1:0] lo_in [4];
    logic [DIG_W-1:0] hi_in [4];
    logic [DIG_W-1:0] lo_reg [4];
    logic [DIG_W-1:0] hi_reg [4];
    logic             mark_set_reg;

    logic [DIG_W-1:0] dig_reg [4];
    logic [DIG_W-1:0] dig_next [4];
    logic [1:0]       axis_reg;
    logic [ROW_AW-1:0] clr_reg;
    logic [CQ_W-1:0]  cq_reg;
    logic [CQ_W-1:0]  cq_prev;

    logic [CNT_W-1:0] run_m_reg, run_n_reg;
    logic [CNT_W-1:0] base_m, base_n, add_m, add_n, new_m, new_n;
    logic signed [ACC_W-1:0] acc_m_reg, acc_n_reg;
    logic [ACC_W-1:0] ext_m, ext_n;
    logic             neg;

    logic             row_we;
    logic [ROW_AW-1:0] row_addr;
    logic [ROW_W-1:0] row_wdata, row_rdata;
    logic             tab_we;
    logic [TAB_AW-1:0] tab_addr;
    logic [TAB_W-1:0] tab_wdata, tab_rdata;

    logic [DIG_W-1:0] pick [4];
    logic [DIG_W-1:0] inner;
    logic [DIG_W-1:0] dsel;
    logic [SUM_W6-1:0] mark_sum, seed_sum;
    logic             on_sum, seed_bit, carry;
    logic             mem_pos, non_pos;

    logic             done_reg, all_reg, any_reg;
    status_t          status_reg;

    assign lo_in[0] = first_low;
    assign lo_in[1] = second_low;
    assign lo_in[2] = third_low;
    assign lo_in[3] = fourth_low;
    assign hi_in[0] = first_high;
    assign hi_in[1] = second_high;
    assign hi_in[2] = third_high;
    assign hi_in[3] = fourth_high;

    // input checks and sweep status
    always_comb
    begin
        mark_sum = SUM_W6'(lo_in[0]) + SUM_W6'(lo_in[1])
                 + SUM_W6'(lo_in[2]) + SUM_W6'(lo_in[3]);
        sts.mark_bad    = (mark_sum != TOTAL);
        sts.query_bad   = 1'b0;
        sts.query_empty = 1'b0;
        for (int j = 0; j < 4; j++)
        begin
            if (lo_in[j] > MAX_DIG)
            begin
                sts.mark_bad  = 1'b1;
                sts.query_bad = 1'b1;
            end
            if (hi_in[j] > MAX_DIG)
            begin
                sts.query_bad = 1'b1;
            end
            if (lo_in[j] > hi_in[j])
            begin
                sts.query_empty = 1'b1;
            end
        end
        sts.inner_last = (inner == LIM);
        sts.cnt_last   = (dig_reg[0] == LIM) && (dig_reg[1] == LIM)
                      && (dig_reg[2] == LIM) && (dig_reg[3] == LIM);
        sts.axis_zero  = (axis_reg == 2'd0);
        sts.clr_last   = &clr_reg;
        sts.q_last     = (cq_reg == CQ_W'(CORNERS));
    end

    // sweep counter: the current axis runs innermost
    always_comb
    begin
        inner = dig_reg[axis_reg];
        for (int j = 0; j < 4; j++)
        begin
            dig_next[j] = dig_reg[j];
        end
        carry = (inner == LIM);
        dig_next[axis_reg] = carry ? '0 : inner + DIG_W'(1);
        for (int j = 3; j >= 0; j--)
        begin
            if ((2'(j) != axis_reg) && carry)
            begin
                if (dig_reg[j] == LIM)
                begin
                    dig_next[j] = '0;
                end
                else
                begin
                    dig_next[j] = dig_reg[j] + DIG_W'(1);
                    carry = 1'b0;
                end
            end
        end
    end

    // member rows
    always_comb
    begin
        if (cmd.clear)
        begin
            row_addr = clr_reg;
        end
        else if (cmd.seed)
        begin
            row_addr = {dig_reg[0] - DIG_W'(1), dig_reg[1] - DIG_W'(1),
                        dig_reg[2] - DIG_W'(1)};
        end
        else
        begin
            row_addr = {lo_reg[0], lo_reg[1], lo_reg[2]};
        end
        row_wdata = row_rdata;
        row_wdata[lo_reg[3]] = mark_set_reg;
        if (cmd.clear)
        begin
            row_wdata = '0;
        end
    end

    assign row_we = cmd.clear | cmd.mark_wr;

    // seed: shifted cell on the target sum takes its tuple's member bit
    always_comb
    begin
        dsel     = dig_reg[3] - DIG_W'(1);
        seed_bit = row_rdata[dsel];
        seed_sum = SUM_W6'(dig_reg[0]) + SUM_W6'(dig_reg[1])
                 + SUM_W6'(dig_reg[2]) + SUM_W6'(dig_reg[3]);
        on_sum   = (seed_sum == SEED_TOTAL) && (dig_reg[0] != '0)
                && (dig_reg[1] != '0) && (dig_reg[2] != '0) && (dig_reg[3] != '0);
    end

    // running sums along the axis
    always_comb
    begin
        base_m = (inner == '0) ? '0 : run_m_reg;
        base_n = (inner == '0) ? '0 : run_n_reg;
        if (cmd.seed_wr)
        begin
            add_m = CNT_W'(on_sum & seed_bit);
            add_n = CNT_W'(on_sum & ~seed_bit);
        end
        else
        begin
            add_m = tab_rdata[TAB_W-1:CNT_W];
            add_n = tab_rdata[CNT_W-1:0];
        end
        new_m = base_m + add_m;
        new_n = base_n + add_n;
    end

    // query corners
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            pick[j] = cq_reg[j] ? hi_reg[j] + DIG_W'(1) : lo_reg[j];
        end
    end

    assign tab_addr  = cmd.query ? {pick[0], pick[1], pick[2], pick[3]}
                                 : {dig_reg[0], dig_reg[1], dig_reg[2], dig_reg[3]};
    assign tab_we    = cmd.seed_wr | cmd.pass_wr;
    assign tab_wdata = {new_m, new_n};

    assign cq_prev = cq_reg - CQ_W'(1);
    assign neg     = ^cq_prev[3:0];
    assign ext_m   = {{(ACC_W-CNT_W){1'b0}}, tab_rdata[TAB_W-1:CNT_W]};
    assign ext_n   = {{(ACC_W-CNT_W){1'b0}}, tab_rdata[CNT_W-1:0]};
    assign mem_pos = (acc_m_reg > 0);
    assign non_pos = (acc_n_reg > 0);

    bcq_ram #(.WIDTH(ROW_W), .DEPTH(ROW_DEPTH)) u_rows (
        .clk   (clk),
        .we    (row_we),
        .addr  (row_addr),
        .wdata (row_wdata),
        .rdata (row_rdata)
    );

    bcq_ram #(.WIDTH(TAB_W), .DEPTH(TAB_DEPTH)) u_tab (
        .clk   (clk),
        .we    (tab_we),
        .addr  (tab_addr),
        .wdata (tab_wdata),
        .rdata (tab_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + ROW_AW'(1);
            end
            done_reg <= cmd.emit | cmd.emit_query;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int j = 0; j < 4; j++)
            begin
                lo_reg[j]  <= lo_in[j];
                hi_reg[j]  <= hi_in[j];
                dig_reg[j] <= '0;
            end
            mark_set_reg <= (operation == OP_MARK_IN);
            axis_reg     <= 2'd3;
            cq_reg       <= '0;
            acc_m_reg    <= '0;
            acc_n_reg    <= '0;
        end
        else
        begin
            if (cmd.seed_wr | cmd.pass_wr)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    dig_reg[j] <= dig_next[j];
                end
                run_m_reg <= new_m;
                run_n_reg <= new_n;
            end
            if (cmd.axis_dec)
            begin
                axis_reg <= axis_reg - 2'd1;
            end
            if (cmd.query)
            begin
                cq_reg <= cq_reg + CQ_W'(1);
                if (cq_reg != '0)
                begin
                    acc_m_reg <= neg ? acc_m_reg - signed'(ext_m) : acc_m_reg + signed'(ext_m);
                    acc_n_reg <= neg ? acc_n_reg - signed'(ext_n) : acc_n_reg + signed'(ext_n);
                end
            end
        end
        if (cmd.emit_query)
        begin
            if (!mem_pos && !non_pos)
            begin
                status_reg <= STAT_EMPTY;
                all_reg    <= 1'b0;
                any_reg    <= 1'b0;
            end
            else
            begin
                status_reg <= STAT_OK;
                all_reg    <= ~non_pos;
                any_reg    <= mem_pos;
            end
        end
        else if (cmd.emit)
        begin
            status_reg <= cmd.code;
            all_reg    <= 1'b0;
            any_reg    <= 1'b0;
        end
    end

    assign done        = done_reg;
    assign all_members = all_reg;
    assign any_member  = any_reg;
    assign status      = status_reg;

endmodule : bcq_dp
`default_nettype wire

@@ rtl/bcq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcq_ctrl: controller
// Sequences the reset clear, marks, the table build and corner queries.
// ----------------------------------------------------------------------------
module bcq_ctrl
    import bcq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] operation,
    input  wire sts_t       sts,
    output      cmd_t       cmd,
    output      logic       busy
);

    state_t state_reg, state_next;
    logic   built_reg, built_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            built_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            built_reg <= built_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.code   = STAT_OK;
        state_next = state_reg;
        built_next = built_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (op_t'(operation))
                        OP_MARK_IN, OP_MARK_OUT:
                        begin
                            if (built_reg)
                            begin
                                cmd.emit = 1'b1;
                                cmd.code = STAT_BUILT;
                            end
                            else if (sts.mark_bad)
                            begin
                                cmd.emit = 1'b1;
                                cmd.code = STAT_BAD;
                            end
                            else
                            begin
                                state_next = S_MARK_RD;
                            end
                        end
                        OP_BUILD:
                        begin
                            if (built_reg)
                            begin
                                cmd.emit = 1'b1;
                                cmd.code = STAT_BUILT;
                            end
                            else
                            begin
                                state_next = S_SEED_RD;
                            end
                        end
                        default:
                        begin
                            if (!built_reg)
                            begin
                                cmd.emit = 1'b1;
                                cmd.code = STAT_UNBUILT;
                            end
                            else if (sts.query_bad)
                            begin
                                cmd.emit = 1'b1;
                                cmd.code = STAT_BAD;
                            end
                            else if (sts.query_empty)
                            begin
                                cmd.emit = 1'b1;
                                cmd.code = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = S_QUERY;
                            end
                        end
                    endcase
                end
            end
            S_MARK_RD:
            begin
                state_next = S_MARK_WR;
            end
            S_MARK_WR:
            begin
                cmd.mark_wr = 1'b1;
                cmd.emit    = 1'b1;
                state_next  = S_IDLE;
            end
            S_SEED_RD:
            begin
                cmd.seed   = 1'b1;
                state_next = S_SEED_WR;
            end
            S_SEED_WR:
            begin
                cmd.seed    = 1'b1;
                cmd.seed_wr = 1'b1;
                if (sts.cnt_last)
                begin
                    cmd.axis_dec = 1'b1;
                    state_next   = S_PASS_RD;
                end
                else if (sts.inner_last)
                begin
                    state_next = S_SEED_RD;
                end
            end
            S_PASS_RD:
            begin
                state_next = S_PASS_WR;
            end
            S_PASS_WR:
            begin
                cmd.pass_wr = 1'b1;
                state_next  = S_PASS_RD;
                if (sts.cnt_last)
                begin
                    if (sts.axis_zero)
                    begin
                        cmd.emit   = 1'b1;
                        built_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.axis_dec = 1'b1;
                    end
                end
            end
            S_QUERY:
            begin
                cmd.query = 1'b1;
                if (sts.q_last)
                begin
                    state_next = S_QFIN;
                end
            end
            S_QFIN:
            begin
                cmd.emit_query = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

`ifndef ASSERT_OFF
    a_no_emit_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !(cmd.emit || cmd.emit_query))
        else $error("result emitted during reset clear");
    a_built_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        built_reg |=> built_reg)
        else $error("tables-built flag dropped");
    a_no_mark_after_build: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mark_wr || cmd.seed_wr) |-> !built_reg)
        else $error("member or table write after build");
    a_query_needs_build: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.query |-> built_reg)
        else $error("corner read before build");
    a_qfin_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QFIN) |=> (state_reg == S_IDLE))
        else $error("query finish did not return to idle");
`endif

endmodule : bcq_ctrl
`default_nettype wire

@@ rtl/box_count_shape_set_query.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// box_count_shape_set_query: membership set over 4-tuples with box queries
// Marks tuple membership, builds 4D summed-area count tables and answers
// box queries from sixteen table corners.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; each word gives exactly
// one result, shown for one cycle with done high, which the receiver must take
// as it comes. After reset the block clears all 4096 member rows (busy high)
// before it takes its first word. Steps per word, paced by the single-port
// table and member RAMs: a rejected word (any error status) gives its result
// the next cycle; a mark does a row read, a row write, then the result; a query
// does sixteen corner reads, one corner a cycle, an add of the last corner,
// the verdict, then the result; the build does a seeding pass that also writes
// the first running sum, then three read-add-write running-sum passes.
// Both count tables share one 20-bit wide RAM.
// ----------------------------------------------------------------------------
module box_count_shape_set_query
    import bcq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output      logic       busy,
    input  wire logic [1:0] operation,
    input  wire logic [3:0] first_low,
    input  wire logic [3:0] first_high,
    input  wire logic [3:0] second_low,
    input  wire logic [3:0] second_high,
    input  wire logic [3:0] third_low,
    input  wire logic [3:0] third_high,
    input  wire logic [3:0] fourth_low,
    input  wire logic [3:0] fourth_high,
    output      logic       done,
    output      logic       all_members,
    output      logic       any_member,
    output      logic [2:0] status
);

    cmd_t cmd;
    sts_t sts;
    logic busy_int;

    // controller: decides each word's fate and steps the long sweeps
    bcq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy_int)
    );

    // datapath: RAMs, counters and the result register
    bcq_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .operation   (operation),
        .first_low   (first_low),
        .first_high  (first_high),
        .second_low  (second_low),
        .second_high (second_high),
        .third_low   (third_low),
        .third_high  (third_high),
        .fourth_low  (fourth_low),
        .fourth_high (fourth_high),
        .cmd         (cmd),
        .sts         (sts),
        .done        (done),
        .all_members (all_members),
        .any_member  (any_member),
        .status      (status)
    );

    assign busy = busy_int;

endmodule : box_count_shape_set_query
`default_nettype wire
